// File: rtl/bbu_pkg.sv
package bbu_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned TolW    = 12;
  localparam int unsigned DistW   = 50;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned SqW     = 2 * CoordW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [TolW-1:0]          tol_t;
  typedef logic [DistW-1:0]         dist_t;

  // Command codes; 6 and 7 are no-ops
  typedef enum logic [2:0] {
    CMD_GROW_POINT = 3'd0,
    CMD_GROW_BOX   = 3'd1,
    CMD_PT_INSIDE  = 3'd2,
    CMD_BOX_INSIDE = 3'd3,
    CMD_DIST_SQ    = 3'd4,
    CMD_LOAD_BOX   = 3'd5
  } cmd_e;

  // Reset corners: -0.5 and +0.5 in Q11.12
  localparam coord_t HalfQ12    = 24'sd2048;
  localparam coord_t NegHalfQ12 = -24'sd2048;

  typedef struct packed {
    logic [2:0] command;
    coord_t     a_x;
    coord_t     a_y;
    coord_t     a_z;
    coord_t     b_x;
    coord_t     b_y;
    coord_t     b_z;
  } in_item_t;

  typedef struct packed {
    logic   inside_res;
    dist_t  distance_squared;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } out_item_t;

endpackage

// File: rtl/bbu_if.sv
interface bbu_in_if;
  import bbu_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bbu_out_if;
  import bbu_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/bounding_box_unit.sv
// Axis-aligned 3D bounding box engine, signed Q11.12 coordinates.
// Usage:
//   in_i  : command transactions (valid/ready), one command plus points a, b.
//   out_o : one result transaction per command, carrying the inside flag,
//           the squared distance and the box corners after the command.
//   cfg_we_i/cfg_wdata_i : writes zero_tolerance; write only while idle.
// Timing:
//   A command is captured in an input register, evaluated against the box
//   combinationally, and its result is registered once the result register
//   is free. Throughput is one command per cycle while out_o.ready stays high;
//   the box update, three compares per axis and three 24x24 squarings all
//   sit in the evaluate logic between the input and result registers.
// Reset:
//   Box goes to [-0.5, +0.5] on every axis, tolerance to 0, both registers
//   empty.
// Stalls:
//   When out_o.ready is low the result is held; the input register still
//   takes one more command, then in_i.ready drops until the result drains.
module bounding_box_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  bbu_pkg::tol_t       cfg_wdata_i,
  bbu_in_if.sink              in_i,
  bbu_out_if.source           out_o
);
  import bbu_pkg::*;

  // Pipeline and state registers
  in_item_t  s1_q;
  logic      s1_valid_q, s1_valid_d;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  tol_t      tol_q;
  coord_t    lo_q [NumAxes];
  coord_t    hi_q [NumAxes];
  coord_t    lo_d [NumAxes];
  coord_t    hi_d [NumAxes];

  logic      out_free, s1_fire, in_fire;
  cmd_e      cmd;
  coord_t    a [NumAxes];
  coord_t    b [NumAxes];

  logic                    box_empty, arg_empty;
  logic                    pt_in, box_in;
  logic signed [CoordW:0]  below [NumAxes];
  logic signed [CoordW:0]  above [NumAxes];
  logic [CoordW-1:0]       dist_ax [NumAxes];
  logic [SqW-1:0]          sq [NumAxes];
  dist_t                   dist_sum;

  // Handshake
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Unpack operands
  assign cmd  = cmd_e'(s1_q.command);
  assign a[0] = s1_q.a_x;
  assign a[1] = s1_q.a_y;
  assign a[2] = s1_q.a_z;
  assign b[0] = s1_q.b_x;
  assign b[1] = s1_q.b_y;
  assign b[2] = s1_q.b_z;

  // Emptiness: all six corner coordinates within tolerance of zero
  always_comb begin
    logic [CoordW-1:0] mag;
    box_empty = 1'b1;
    arg_empty = 1'b1;
    for (int i = 0; i < NumAxes; i++) begin
      mag = lo_q[i][CoordW-1] ? CoordW'(-lo_q[i]) : CoordW'(lo_q[i]);
      if (mag > CoordW'(tol_q)) box_empty = 1'b0;
      mag = hi_q[i][CoordW-1] ? CoordW'(-hi_q[i]) : CoordW'(hi_q[i]);
      if (mag > CoordW'(tol_q)) box_empty = 1'b0;
      mag = a[i][CoordW-1] ? CoordW'(-a[i]) : CoordW'(a[i]);
      if (mag > CoordW'(tol_q)) arg_empty = 1'b0;
      mag = b[i][CoordW-1] ? CoordW'(-b[i]) : CoordW'(b[i]);
      if (mag > CoordW'(tol_q)) arg_empty = 1'b0;
    end
  end

  // Containment tests, inclusive bounds
  always_comb begin
    pt_in  = 1'b1;
    box_in = 1'b1;
    for (int i = 0; i < NumAxes; i++) begin
      if (a[i] < lo_q[i] || a[i] > hi_q[i]) pt_in = 1'b0;
      if (a[i] < lo_q[i] || b[i] > hi_q[i]) box_in = 1'b0;
    end
  end

  // Per-axis distance outside the box and its square
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      below[i] = (CoordW+1)'(lo_q[i]) - (CoordW+1)'(a[i]);
      above[i] = (CoordW+1)'(a[i]) - (CoordW+1)'(hi_q[i]);
      dist_ax[i] = '0;
      if (below[i] > 0) dist_ax[i] = below[i][CoordW-1:0];
      if (above[i] > 0 && above[i] > $signed({1'b0, dist_ax[i]})) begin
        dist_ax[i] = above[i][CoordW-1:0];
      end
      sq[i] = SqW'(dist_ax[i]) * SqW'(dist_ax[i]);
    end
    dist_sum = DistW'(sq[0]) + DistW'(sq[1]) + DistW'(sq[2]);
  end

  // Box update
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      lo_d[i] = lo_q[i];
      hi_d[i] = hi_q[i];
      case (cmd)
        CMD_GROW_POINT: begin
          if (box_empty) begin
            lo_d[i] = a[i];
            hi_d[i] = a[i];
          end else begin
            if (a[i] < lo_q[i]) lo_d[i] = a[i];
            if (a[i] > hi_q[i]) hi_d[i] = a[i];
          end
        end
        CMD_GROW_BOX: begin
          if (!arg_empty) begin
            if (box_empty) begin
              lo_d[i] = a[i];
              hi_d[i] = b[i];
            end else begin
              if (a[i] < lo_q[i]) lo_d[i] = a[i];
              if (b[i] > hi_q[i]) hi_d[i] = b[i];
            end
          end
        end
        CMD_LOAD_BOX: begin
          lo_d[i] = a[i];
          hi_d[i] = b[i];
        end
        default: ;
      endcase
    end
  end

  // Result assembly
  always_comb begin
    out_d.inside_res       = (cmd == CMD_PT_INSIDE  && pt_in) ||
                             (cmd == CMD_BOX_INSIDE && box_in);
    out_d.distance_squared = (cmd == CMD_DIST_SQ) ? dist_sum : '0;
    out_d.box_min_x        = lo_d[0];
    out_d.box_min_y        = lo_d[1];
    out_d.box_min_z        = lo_d[2];
    out_d.box_max_x        = hi_d[0];
    out_d.box_max_y        = hi_d[1];
    out_d.box_max_z        = hi_d[2];
  end

  // Valid flags
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_fire) s1_valid_d = 1'b0;
    if (in_fire) s1_valid_d = 1'b1;
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (s1_fire) out_valid_d = 1'b1;
  end

  // Control and box state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tol_q       <= '0;
      for (int i = 0; i < NumAxes; i++) begin
        lo_q[i] <= NegHalfQ12;
        hi_q[i] <= HalfQ12;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      if (s1_fire) begin
        for (int i = 0; i < NumAxes; i++) begin
          lo_q[i] <= lo_d[i];
          hi_q[i] <= hi_d[i];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) s1_q <= in_i.payload;
    if (s1_fire) out_q <= out_d;
  end

  // Assertions
  logic [2*NumAxes*CoordW-1:0] box_flat;
  assign box_flat = {lo_q[0], lo_q[1], lo_q[2], hi_q[0], hi_q[1], hi_q[2]};

  a_box_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(box_flat))
    else $error("box changed without an evaluated command");

  a_query_keeps_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (cmd == CMD_PT_INSIDE || cmd == CMD_BOX_INSIDE ||
                cmd == CMD_DIST_SQ) |=> $stable(box_flat))
    else $error("query command modified the box");

  a_load_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && cmd == CMD_LOAD_BOX |=>
      lo_q[0] == $past(s1_q.a_x) && hi_q[2] == $past(s1_q.b_z))
    else $error("load did not store the given corners");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.inside_res && out_q.distance_squared != '0))
    else $error("inside flag and distance both set");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled with empty input register");

endmodule
